@@ rtl/core/bsc_pkg.sv @@
// shared types, codes and sizes for the banker's safety check unit
package bsc_pkg;

  localparam int NPROC   = 16;
  localparam int NRES    = 4;
  localparam int COUNT_W = 8;
  localparam int PID_W   = $clog2(NPROC);
  localparam int NUM_W   = $clog2(NPROC) + 1;
  localparam int ROW_W   = NRES * COUNT_W;

  typedef logic [COUNT_W-1:0]           cnt_t;
  typedef logic [NRES-1:0][COUNT_W-1:0] row_t;
  typedef logic [PID_W-1:0]             pid_t;
  typedef logic [NUM_W-1:0]             num_t;
  typedef logic [1:0]                   code_t;

  // request kinds
  localparam code_t REQ_SET_FREE = 2'd0;
  localparam code_t REQ_LOAD_ROW = 2'd1;
  localparam code_t REQ_REQUEST  = 2'd2;
  // unused kind, accepted and dropped without a result
  localparam code_t REQ_NONE     = 2'd3;

  // result status codes
  localparam code_t STAT_OK      = 2'd0;
  localparam code_t STAT_ROW_REJ = 2'd1;
  localparam code_t STAT_EXCEEDS = 2'd2;
  localparam code_t STAT_UNSAFE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ_CHK,
    S_PASS,
    S_PASS_END,
    S_COMMIT,
    S_RESP,
    S_EMIT
  } fsm_t;

endpackage

@@ rtl/core/bsc_if.sv @@
// valid/ready channel interfaces for items in and results out
interface bsc_in_if;
  logic                  valid;
  logic                  ready;
  bsc_pkg::code_t        req_type;
  bsc_pkg::pid_t         proc_id;
  bsc_pkg::cnt_t         amt0;
  bsc_pkg::cnt_t         amt1;
  bsc_pkg::cnt_t         amt2;
  bsc_pkg::cnt_t         amt3;
  bsc_pkg::cnt_t         max0;
  bsc_pkg::cnt_t         max1;
  bsc_pkg::cnt_t         max2;
  bsc_pkg::cnt_t         max3;

  modport source (output valid, req_type, proc_id, amt0, amt1, amt2, amt3,
                  max0, max1, max2, max3, input ready);
  modport sink   (input valid, req_type, proc_id, amt0, amt1, amt2, amt3,
                  max0, max1, max2, max3, output ready);
endinterface

interface bsc_out_if;
  logic           valid;
  logic           ready;
  bsc_pkg::code_t status;
  bsc_pkg::pid_t  seq_proc;
  logic           last;

  modport source (output valid, status, seq_proc, last, input ready);
  modport sink   (input valid, status, seq_proc, last, output ready);
endinterface

@@ rtl/core/bsc_ram.sv @@
// generic single-write, single-read ram with registered read data
module bsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/bsc_row_eval.sv @@
// fit test of one process row against the work vector, and the work update
module bsc_row_eval (
  input  bsc_pkg::row_t need,
  input  bsc_pkg::row_t alloc,
  input  bsc_pkg::row_t work,
  input  bsc_pkg::row_t amt,
  input  logic          is_pid,
  output logic          fits,
  output bsc_pkg::row_t work_new
);
  import bsc_pkg::*;

  cnt_t             nd  [NRES];
  cnt_t             al  [NRES];
  logic [COUNT_W:0] sum [NRES];

  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < NRES; r++) begin
      // requester row is seen with the request already granted
      nd[r]  = is_pid ? cnt_t'(need[r] - amt[r]) : need[r];
      al[r]  = is_pid ? cnt_t'(alloc[r] + amt[r]) : alloc[r];
      sum[r] = {1'b0, work[r]} + {1'b0, al[r]};
      work_new[r] = sum[r][COUNT_W] ? {COUNT_W{1'b1}} : sum[r][COUNT_W-1:0];
      if (nd[r] > work[r]) begin
        fits = 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/bankers_safety_check_unit.sv @@
// banker's safety check: set/load items give one result in the cycle after accept
// a request gets bound checks, then passes over the process table (one ram read per
// row), at most n passes; a safe request then emits its order at one item per cycle
// unless the output stalls; one item at a time
// reset clears control, free vector to zero and num_procs to 1; tables not cleared
module bankers_safety_check_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  bsc_in_if.sink              in_ch,
  bsc_out_if.source           out_ch
);
  import bsc_pkg::*;

  fsm_t  state_r, state_nxt;
  num_t  num_r;
  row_t  free_r, free_nxt;
  pid_t  req_pid_r, req_pid_nxt;
  row_t  req_amt_r, req_amt_nxt;
  row_t  req_alloc_r, req_alloc_nxt;
  row_t  req_need_r, req_need_nxt;
  row_t  work_r, work_nxt;
  logic [NPROC-1:0] done_r, done_nxt;
  pid_t  order_r [NPROC];
  logic  order_we;
  num_t  cnt_r, cnt_nxt;
  pid_t  eval_idx_r, eval_idx_nxt;
  logic  progress_r, progress_nxt;
  code_t resp_r, resp_nxt;
  pid_t  emit_idx_r, emit_idx_nxt;

  logic  out_valid_r;
  code_t out_status_r;
  pid_t  out_proc_r;
  logic  out_last_r;
  logic  push;
  code_t push_status;
  pid_t  push_proc;
  logic  push_last;
  logic  slot_free;

  num_t  n_eff;
  pid_t  n_last;
  row_t  in_amt, in_max;
  logic  in_acc;
  logic  row_bad;
  logic  req_bad;
  logic  emit_last;

  logic  ram_we;
  pid_t  ram_waddr, ram_raddr;
  row_t  alloc_wdata, need_wdata;
  logic [ROW_W-1:0] alloc_rdata, need_rdata;
  row_t  alloc_row, need_row;

  logic  fits;
  row_t  work_new;

  assign in_amt = {in_ch.amt3, in_ch.amt2, in_ch.amt1, in_ch.amt0};
  assign in_max = {in_ch.max3, in_ch.max2, in_ch.max1, in_ch.max0};
  assign alloc_row = row_t'(alloc_rdata);
  assign need_row  = row_t'(need_rdata);

  // clamp register to 1..NPROC
  always_comb begin
    if (num_r == '0) begin
      n_eff = num_t'(1);
    end else if (num_r > num_t'(NPROC)) begin
      n_eff = num_t'(NPROC);
    end else begin
      n_eff = num_r;
    end
  end
  assign n_last = pid_t'(n_eff - num_t'(1));

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && slot_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign emit_last    = ({1'b0, emit_idx_r} + num_t'(1)) == cnt_r;

  always_comb begin
    row_bad = 1'b0;
    req_bad = 1'b0;
    for (int r = 0; r < NRES; r++) begin
      if (in_max[r] < in_amt[r]) row_bad = 1'b1;
      if (req_amt_r[r] > need_row[r] || req_amt_r[r] > free_r[r]) req_bad = 1'b1;
    end
  end

  bsc_ram #(.WIDTH(ROW_W), .DEPTH(NPROC)) u_alloc_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (alloc_wdata),
    .rd_addr (ram_raddr),
    .rd_data (alloc_rdata)
  );

  bsc_ram #(.WIDTH(ROW_W), .DEPTH(NPROC)) u_need_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (need_wdata),
    .rd_addr (ram_raddr),
    .rd_data (need_rdata)
  );

  bsc_row_eval u_eval (
    .need     (need_row),
    .alloc    (alloc_row),
    .work     (work_r),
    .amt      (req_amt_r),
    .is_pid   (eval_idx_r == req_pid_r),
    .fits     (fits),
    .work_new (work_new)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.req_type == REQ_REQUEST &&
            {1'b0, in_ch.proc_id} < n_eff) begin
          state_nxt = S_REQ_CHK;
        end
      end
      S_REQ_CHK:  state_nxt = req_bad ? S_RESP : S_PASS;
      S_PASS:     if (eval_idx_r == n_last) state_nxt = S_PASS_END;
      S_PASS_END: begin
        if (cnt_r == n_eff) begin
          state_nxt = S_COMMIT;
        end else if (!progress_r) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_PASS;
        end
      end
      S_COMMIT:   state_nxt = S_EMIT;
      S_RESP:     if (slot_free) state_nxt = S_IDLE;
      S_EMIT:     if (slot_free && emit_last) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    free_nxt      = free_r;
    req_pid_nxt   = req_pid_r;
    req_amt_nxt   = req_amt_r;
    req_alloc_nxt = req_alloc_r;
    req_need_nxt  = req_need_r;
    work_nxt      = work_r;
    done_nxt      = done_r;
    order_we      = 1'b0;
    cnt_nxt       = cnt_r;
    eval_idx_nxt  = eval_idx_r;
    progress_nxt  = progress_r;
    resp_nxt      = resp_r;
    emit_idx_nxt  = emit_idx_r;
    ram_we        = 1'b0;
    ram_waddr     = req_pid_r;
    ram_raddr     = '0;
    alloc_wdata   = in_amt;
    need_wdata    = in_amt;
    push          = 1'b0;
    push_status   = STAT_OK;
    push_proc     = '0;
    push_last     = 1'b1;
    case (state_r)
      S_IDLE: begin
        ram_raddr   = in_ch.proc_id;
        req_pid_nxt = in_ch.proc_id;
        req_amt_nxt = in_amt;
        if (in_acc) begin
          case (in_ch.req_type)
            REQ_SET_FREE: begin
              free_nxt = in_amt;
              push     = 1'b1;
            end
            REQ_LOAD_ROW: begin
              push = 1'b1;
              if (row_bad) begin
                push_status = STAT_ROW_REJ;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = in_ch.proc_id;
                for (int r = 0; r < NRES; r++) begin
                  need_wdata[r] = cnt_t'(in_max[r] - in_amt[r]);
                end
              end
            end
            REQ_REQUEST: begin
              if ({1'b0, in_ch.proc_id} >= n_eff) begin
                push        = 1'b1;
                push_status = STAT_EXCEEDS;
              end
            end
            default: ;
          endcase
        end
      end
      S_REQ_CHK: begin
        resp_nxt      = STAT_EXCEEDS;
        req_alloc_nxt = alloc_row;
        req_need_nxt  = need_row;
        done_nxt      = '0;
        cnt_nxt       = '0;
        eval_idx_nxt  = '0;
        progress_nxt  = 1'b0;
        for (int r = 0; r < NRES; r++) begin
          work_nxt[r] = cnt_t'(free_r[r] - req_amt_r[r]);
        end
      end
      S_PASS: begin
        // read for the following row goes out while this one is evaluated
        ram_raddr    = pid_t'(eval_idx_r + pid_t'(1));
        eval_idx_nxt = pid_t'(eval_idx_r + pid_t'(1));
        if (fits && !done_r[eval_idx_r]) begin
          work_nxt             = work_new;
          done_nxt[eval_idx_r] = 1'b1;
          order_we             = 1'b1;
          cnt_nxt              = num_t'(cnt_r + num_t'(1));
          progress_nxt         = 1'b1;
        end
      end
      S_PASS_END: begin
        resp_nxt     = STAT_UNSAFE;
        eval_idx_nxt = '0;
        progress_nxt = 1'b0;
      end
      S_COMMIT: begin
        ram_we       = 1'b1;
        emit_idx_nxt = '0;
        for (int r = 0; r < NRES; r++) begin
          free_nxt[r]    = cnt_t'(free_r[r] - req_amt_r[r]);
          alloc_wdata[r] = cnt_t'(req_alloc_r[r] + req_amt_r[r]);
          need_wdata[r]  = cnt_t'(req_need_r[r] - req_amt_r[r]);
        end
      end
      S_RESP: begin
        push        = slot_free;
        push_status = resp_r;
      end
      S_EMIT: begin
        push      = slot_free;
        push_proc = order_r[emit_idx_r];
        push_last = emit_last;
        if (slot_free) emit_idx_nxt = pid_t'(emit_idx_r + pid_t'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_r       <= num_t'(1);
      free_r      <= '0;
      out_valid_r <= 1'b0;
      done_r      <= '0;
      cnt_r       <= '0;
      progress_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      free_r     <= free_nxt;
      done_r     <= done_nxt;
      cnt_r      <= cnt_nxt;
      progress_r <= progress_nxt;
      if (cfg_we) num_r <= num_t'(cfg_wdata);
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_pid_r   <= req_pid_nxt;
    req_amt_r   <= req_amt_nxt;
    req_alloc_r <= req_alloc_nxt;
    req_need_r  <= req_need_nxt;
    work_r      <= work_nxt;
    eval_idx_r  <= eval_idx_nxt;
    resp_r      <= resp_nxt;
    emit_idx_r  <= emit_idx_nxt;
    if (order_we) order_r[cnt_r[PID_W-1:0]] <= eval_idx_r;
    if (push) begin
      out_status_r <= push_status;
      out_proc_r   <= push_proc;
      out_last_r   <= push_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.seq_proc = out_proc_r;
  assign out_ch.last     = out_last_r;

endmodule

@@ dv/tb_bankers_safety_check_unit.sv @@
// self-checking testbench for the banker's safety check unit
module tb_bankers_safety_check_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 320;

  typedef struct {
    code_t kind;
    pid_t  pid;
    cnt_t  amt [NRES];
    cnt_t  mx  [NRES];
  } bank_item_t;

  typedef struct {
    code_t status;
    pid_t  seq;
    logic  last;
  } grant_t;

  // tracks the resource ledger and the results each accepted item owes
  class bankers_ledger;
    cnt_t   free_cnt [NRES];
    cnt_t   held [NPROC][NRES];
    cnt_t   owed [NPROC][NRES];
    int     active;
    grant_t pending_results [$];
    int     errors;
    int     n_results, n_safe, n_unsafe, n_rejected;

    function new();
      active = 1;
      foreach (free_cnt[r]) free_cnt[r] = '0;
      foreach (held[p, r]) begin
        held[p][r] = '0;
        owed[p][r] = '0;
      end
    endfunction

    function void set_procs(logic [4:0] v);
      active = (v == 0) ? 1 : (v > NPROC) ? NPROC : int'(v);
    endfunction

    function void push(code_t st, pid_t p, logic l);
      grant_t g;
      g.status = st;
      g.seq = p;
      g.last = l;
      pending_results.push_back(g);
    endfunction

    function void note_item(bank_item_t it);
      logic [8:0] work [NRES];
      cnt_t       nd;
      logic [8:0] s;
      bit         done [NPROC];
      pid_t       order [NPROC];
      int         cnt;
      bit         progress, fits, bad;
      case (it.kind)
        REQ_SET_FREE: begin
          foreach (free_cnt[r]) free_cnt[r] = it.amt[r];
          push(STAT_OK, '0, 1'b1);
        end
        REQ_LOAD_ROW: begin
          bad = 0;
          for (int r = 0; r < NRES; r++) if (it.mx[r] < it.amt[r]) bad = 1;
          if (bad) begin
            n_rejected++;
            push(STAT_ROW_REJ, '0, 1'b1);
          end else begin
            for (int r = 0; r < NRES; r++) begin
              held[it.pid][r] = it.amt[r];
              owed[it.pid][r] = it.mx[r] - it.amt[r];
            end
            push(STAT_OK, '0, 1'b1);
          end
        end
        REQ_REQUEST: begin
          bad = (int'(it.pid) >= active);
          if (!bad)
            for (int r = 0; r < NRES; r++)
              if (it.amt[r] > owed[it.pid][r] || it.amt[r] > free_cnt[r]) bad = 1;
          if (bad) begin
            push(STAT_EXCEEDS, '0, 1'b1);
            return;
          end
          for (int r = 0; r < NRES; r++) work[r] = {1'b0, cnt_t'(free_cnt[r] - it.amt[r])};
          foreach (done[i]) done[i] = 0;
          cnt = 0;
          progress = 1;
          while (progress && cnt < active) begin
            progress = 0;
            for (int i = 0; i < active; i++) begin
              fits = !done[i];
              for (int r = 0; r < NRES; r++) begin
                nd = owed[i][r];
                if (i == it.pid) nd = nd - it.amt[r];
                if ({1'b0, nd} > work[r]) fits = 0;
              end
              if (fits) begin
                for (int r = 0; r < NRES; r++) begin
                  s = work[r] + {1'b0, held[i][r]} +
                      {1'b0, ((i == it.pid) ? it.amt[r] : cnt_t'(0))};
                  work[r] = (s > 255) ? 9'd255 : s;
                end
                done[i] = 1;
                order[cnt] = pid_t'(i);
                cnt++;
                progress = 1;
              end
            end
          end
          if (cnt < active) begin
            n_unsafe++;
            push(STAT_UNSAFE, '0, 1'b1);
            return;
          end
          n_safe++;
          for (int r = 0; r < NRES; r++) begin
            free_cnt[r] -= it.amt[r];
            held[it.pid][r] += it.amt[r];
            owed[it.pid][r] -= it.amt[r];
          end
          for (int i = 0; i < cnt; i++) push(STAT_OK, order[i], i + 1 == cnt);
        end
        default: ;
      endcase
    endfunction

    function void check_result(code_t st, pid_t p, logic l);
      grant_t g;
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d seq_proc=%0d last=%0d", st, p, l);
        errors++;
        return;
      end
      g = pending_results.pop_front();
      if (st !== g.status) begin
        $error("status expected %0d actual %0d", g.status, st);
        errors++;
      end
      if (p !== g.seq) begin
        $error("seq_proc expected %0d actual %0d", g.seq, p);
        errors++;
      end
      if (l !== g.last) begin
        $error("last expected %0d actual %0d", g.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       cfg_we = 0;
  logic [4:0] cfg_wdata = '0;

  bsc_in_if  in_ch();
  bsc_out_if out_ch();

  bankers_safety_check_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always #6 clk = ~clk;

  bankers_ledger ledger = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int n_items = 0;
  int quiet_cycles = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.req_type = '0;
    in_ch.proc_id = '0;
    {in_ch.amt0, in_ch.amt1, in_ch.amt2, in_ch.amt3} = '0;
    {in_ch.max0, in_ch.max1, in_ch.max2, in_ch.max3} = '0;
    out_ch.ready = 0;
  end

  // receiver: random stalls plus one long hold-off in the first random batch
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor and watchdog, sampled mid-cycle when everything is settled
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.check_result(out_ch.status, out_ch.seq_proc, out_ch.last);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(bank_item_t it);
    bit acc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= it.kind;
    in_ch.proc_id  <= it.pid;
    in_ch.amt0 <= it.amt[0];
    in_ch.amt1 <= it.amt[1];
    in_ch.amt2 <= it.amt[2];
    in_ch.amt3 <= it.amt[3];
    in_ch.max0 <= it.mx[0];
    in_ch.max1 <= it.mx[1];
    in_ch.max2 <= it.mx[2];
    in_ch.max3 <= it.mx[3];
    do begin
      @(negedge clk);
      acc = in_ch.valid && in_ch.ready;
      @(posedge clk);
    end while (!acc);
    ledger.note_item(it);
    if (it.kind != REQ_NONE) n_items++;
  endtask

  task automatic drain();
    // drop valid first so the last item is not taken twice
    in_ch.valid <= 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_procs(logic [4:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_procs(v);
  endtask

  function automatic bank_item_t make_item(code_t k, int p, int a, int m);
    bank_item_t it;
    it.kind = k;
    it.pid = pid_t'(p);
    foreach (it.amt[r]) begin
      it.amt[r] = cnt_t'(a);
      it.mx[r] = cnt_t'(m);
    end
    return it;
  endfunction

  function automatic bank_item_t rand_item();
    bank_item_t it;
    int sel, a;
    sel = $urandom_range(99);
    it = make_item(REQ_REQUEST, $urandom_range(NPROC - 1), 0, 0);
    foreach (it.mx[r]) it.mx[r] = cnt_t'($urandom);
    if (sel < 5) begin
      // noise over the whole field range
      it.kind = code_t'($urandom_range(3));
      foreach (it.amt[r]) it.amt[r] = cnt_t'($urandom);
    end else if (sel < 18) begin
      it.kind = REQ_SET_FREE;
      foreach (it.amt[r]) it.amt[r] = cnt_t'($urandom_range(40, 255));
    end else if (sel < 45) begin
      it.kind = REQ_LOAD_ROW;
      foreach (it.amt[r]) begin
        it.amt[r] = cnt_t'($urandom_range(0, 50));
        it.mx[r] = cnt_t'(it.amt[r] + cnt_t'($urandom_range(0, 60)));
      end
      if ($urandom_range(9) == 0)
        it.mx[$urandom_range(NRES - 1)] = cnt_t'(it.amt[0] - cnt_t'(1));
    end else begin
      if ($urandom_range(9) != 0) it.pid = pid_t'($urandom_range(ledger.active - 1));
      foreach (it.amt[r]) begin
        a = ledger.owed[it.pid][r];
        if (a > 12) a = 12;
        it.amt[r] = cnt_t'($urandom_range(0, a) + (($urandom_range(19) == 0) ? 1 : 0));
      end
    end
    return it;
  endfunction

  logic [4:0] proc_settings [9] = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd1, 5'd17, 5'd8, 5'd12, 5'd16};

  initial begin
    bank_item_t it;
    int cnt0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every kind, rejections, ignored kind
    send_item(make_item(REQ_SET_FREE, 0, 255, 0));
    for (int p = 0; p < NPROC; p++)
      send_item(make_item(REQ_LOAD_ROW, p, (p == 15) ? 255 : p, (p == 15) ? 255 : p + 3));
    send_item(make_item(REQ_LOAD_ROW, 3, 9, 8));
    send_item(make_item(REQ_REQUEST, 5, 0, 0));
    send_item(make_item(REQ_REQUEST, 0, 4, 0));
    send_item(make_item(REQ_NONE, 7, 1, 1));
    send_item(make_item(REQ_REQUEST, 0, 2, 0));
    send_item(make_item(REQ_SET_FREE, 0, 0, 0));
    send_item(make_item(REQ_REQUEST, 0, 1, 0));
    send_item(make_item(REQ_SET_FREE, 0, 200, 0));
    drain();

    for (int b = 0; b < 9; b++) begin
      write_procs(b == 6 ? 5'($urandom_range(2, 15)) : proc_settings[b]);
      send_idle_pct = (b < 3) ? 8 : (b < 6) ? 64 : 0;
      recv_idle_pct = (b < 3) ? 64 : (b < 6) ? 8 : 0;
      cnt0 = n_items;
      while (n_items - cnt0 < 20) begin
        if (b == 0 && n_items - cnt0 == 4) begin
          in_ch.valid <= 1'b0;
          @(negedge clk);
          hold_left = 400;
          @(posedge clk);
        end
        send_item(rand_item());
      end
      drain();
    end

    $display("run: %0d items, %0d results; %0d safe orders, %0d unsafe, %0d rows rejected",
             n_items, ledger.n_results, ledger.n_safe, ledger.n_unsafe, ledger.n_rejected);
    $display("run: process counts 1..16 and out-of-range settings, both stall profiles");
    if (ledger.errors == 0 && ledger.pending_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
